@@ rtl/core/htc_pkg.sv @@
// Shared types, constants and the saturation helper for the transform composer.
// No dependencies; every other file in rtl/core takes its names from here.
package htc_pkg;

   localparam int FRAC_BITS_DEFAULT = 16;
   localparam int WORD_W            = 32;
   localparam int ROW_W             = 2;
   localparam int OP_W              = 3;
   localparam int LANES             = 4;
   localparam int CLIP_IN_W         = 64;
   localparam int REQ_DATA_W        = 136;
   localparam int RSP_DATA_W        = 136;

   typedef logic signed [WORD_W-1:0] word_type;

   typedef enum logic [OP_W-1:0] {
      OP_IDENTITY  = 3'd0,
      OP_MUL_ROW   = 3'd1,
      OP_TRANSLATE = 3'd2,
      OP_READ_ROW  = 3'd3,
      OP_INV_ROW   = 3'd4
   } op_type;

   // Where the merge stage takes the columns of a result from.
   typedef enum logic [1:0] {
      RES_PASS    = 2'd0,
      RES_PRODUCT = 2'd1,
      RES_INVERSE = 2'd2
   } res_kind_type;

   typedef struct packed {
      logic              valid;
      res_kind_type      kind;
      logic [ROW_W-1:0]  row;
      logic              commit;
   } stage_ctl_type;

   typedef struct packed {
      logic     sat;
      word_type value;
   } clip_type;

   // Clip a wide signed value into one word, flag when clipped.
   function automatic clip_type clip_word(input logic signed [CLIP_IN_W-1:0] v);
      clip_type r;
      r.sat   = 1'b0;
      r.value = word_type'(v);
      if (v > CLIP_IN_W'(signed'(32'h7FFF_FFFF))) begin
         r.sat   = 1'b1;
         r.value = word_type'(32'h7FFF_FFFF);
      end else if (v < -CLIP_IN_W'(64'sh8000_0000)) begin
         r.sat   = 1'b1;
         r.value = word_type'(32'h8000_0000);
      end
      return r;
   endfunction

endpackage

@@ rtl/core/htc_lane.sv @@
// One column lane: four registered signed products, floor shift, sum and clip.
// Depends on htc_pkg for the word type and clip_word.
module htc_lane #(
   parameter int FRAC_BITS = htc_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     load,
   input  logic signed [32:0]       a_in [4],
   input  htc_pkg::word_type        b_in [4],
   output htc_pkg::word_type        sum_out,
   output logic                     sat_out
);

   localparam int PROD_W = 65;
   localparam int SUM_W  = PROD_W - FRAC_BITS + 2;

   logic signed [PROD_W-1:0] prod_ff [4];
   logic signed [PROD_W-1:0] prod_in [4];
   logic signed [SUM_W-1:0]  sum;
   htc_pkg::clip_type        clip;

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         prod_in[k] = a_in[k] * b_in[k];
      end
   end

   // Hold products until the next word is taken.
   always_ff @(posedge clock) begin
      if (load) begin
         prod_ff <= prod_in;
      end
   end

   // Arithmetic shift right is floor division by 2^FRAC_BITS.
   always_comb begin
      sum = '0;
      for (int k = 0; k < 4; k++) begin
         sum = sum + SUM_W'(prod_ff[k] >>> FRAC_BITS);
      end
      clip    = htc_pkg::clip_word(htc_pkg::CLIP_IN_W'(sum));
      sum_out = clip.value;
      sat_out = clip.sat;
   end

endmodule

@@ rtl/core/htc_merge.sv @@
// Merge stage: combine lane results with pass-through values into the output register.
// Depends on htc_pkg for stage control and result kinds.
module htc_merge (
   input  logic                                clock,
   input  logic                                reset,
   input  htc_pkg::stage_ctl_type              ctl,
   input  htc_pkg::word_type                   pass_val [4],
   input  logic                                pass_sat,
   input  htc_pkg::word_type                   lane_sum [4],
   input  logic [htc_pkg::LANES-1:0]           lane_sat,
   input  logic                                rsp_tready,
   output logic                                rsp_tvalid,
   // rsp_tdata, low bit up: out_row[1:0], out_0, out_1, out_2, out_3, saturated, zero pad
   output logic [htc_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic                                out_free
);

   logic                         out_valid_ff, out_valid_in;
   logic [htc_pkg::ROW_W-1:0]    row_ff, row_in;
   htc_pkg::word_type            val_ff [4];
   htc_pkg::word_type            val_in [4];
   logic                         sat_ff, sat_in;
   logic                         fire;

   assign out_free = !out_valid_ff || rsp_tready;
   assign fire     = ctl.valid && out_free;

   always_comb begin
      row_in = ctl.row;
      val_in = pass_val;
      sat_in = pass_sat;
      unique case (ctl.kind)
         htc_pkg::RES_PRODUCT: begin
            val_in = lane_sum;
            sat_in = |lane_sat;
         end
         htc_pkg::RES_INVERSE: begin
            val_in[3] = lane_sum[3];
            sat_in    = lane_sat[3];
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff && !rsp_tready;
      if (fire) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         row_ff <= row_in;
         val_ff <= val_in;
         sat_ff <= sat_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'b0, sat_ff, val_ff[3], val_ff[2], val_ff[1], val_ff[0], row_ff};

endmodule

@@ rtl/core/homogeneous_transform_composer.sv @@
// Top level of the 4x4 homogeneous transform composer: transform and pending-row store,
// operation decode, four column lanes and the merge stage. Depends on htc_pkg,
// htc_lane and htc_merge.
//
// Usage: request words arrive on req_tvalid/req_tready/req_tdata with the operation
// code on req_tuser (0 identity, 1 left-multiply row, 2 translate, 3 read row,
// 4 read inverse row). Every request word yields exactly one response word on
// rsp_tvalid/rsp_tready/rsp_tdata, in order.
// A taken word first has its products registered, then its merged row registered, before
// it shows on rsp_tvalid.
// Throughput: one word per cycle while the receiver keeps up. A left-multiply of row 3
// holds off the request side until it leaves the product stage, since its commit of the
// new transform lands then and the next word must see the committed matrix.
// The lanes hold one 33x32 multiplier per product; sixteen in all, four per column.
// Reset (synchronous, active high) loads the identity with diagonal 2^FRAC_BITS and
// clears the pending rows; no response is pending afterwards.
// Receiver stall: the output register holds its word; the product stage still
// drains into it when it empties, and the request side keeps taking words as long
// as the product stage is free, so one word can wait while another is accepted.
module homogeneous_transform_composer #(
   parameter int FRAC_BITS = htc_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // req_tdata, low bit up: row_index[1:0], elem_a, elem_b, elem_c, elem_d, zero pad
   input  logic [htc_pkg::REQ_DATA_W-1:0]      req_tdata,
   // req_tuser: req_type[2:0]
   input  logic [htc_pkg::OP_W-1:0]            req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // rsp_tdata, low bit up: out_row[1:0], out_0, out_1, out_2, out_3, saturated, zero pad
   output logic [htc_pkg::RSP_DATA_W-1:0]      rsp_tdata
);

   localparam htc_pkg::word_type ONE_Q = htc_pkg::word_type'(32'd1 << FRAC_BITS);

   // Transform, row by row, and rows 0..2 of a product under way.
   htc_pkg::word_type t_ff    [4][4];
   htc_pkg::word_type t_in    [4][4];
   htc_pkg::word_type pend_ff [3][4];
   htc_pkg::word_type pend_in [3][4];

   // Product stage control and pass-through values.
   htc_pkg::stage_ctl_type s1_ff, s1_in;
   htc_pkg::word_type      s1_pass_ff [4];
   htc_pkg::word_type      s1_pass_in [4];
   logic                   s1_sat_ff, s1_sat_in;

   htc_pkg::op_type            op;
   logic [htc_pkg::ROW_W-1:0]  row;
   htc_pkg::word_type          elem [4];
   htc_pkg::word_type          trans_val [3];
   logic                       trans_sat;

   logic signed [32:0]         lane_a [4][4];
   htc_pkg::word_type          lane_b [4][4];
   htc_pkg::word_type          lane_sum [4];
   logic [htc_pkg::LANES-1:0]  lane_sat;

   logic accept;
   logic out_free;
   logic s1_fire;
   logic commit_fire;

   // ---------------------------------------------------------------- decode
   assign op      = htc_pkg::op_type'(req_tuser);
   assign row     = req_tdata[1:0];
   assign elem[0] = req_tdata[33:2];
   assign elem[1] = req_tdata[65:34];
   assign elem[2] = req_tdata[97:66];
   assign elem[3] = req_tdata[129:98];

   // Hold off new words while a row-3 commit sits in the product stage.
   assign req_tready  = !(s1_ff.valid && s1_ff.commit) && (!s1_ff.valid || out_free);
   assign accept      = req_tvalid && req_tready;
   assign s1_fire     = s1_ff.valid && out_free;
   assign commit_fire = s1_fire && (s1_ff.kind == htc_pkg::RES_PRODUCT) && s1_ff.commit;

   // Saturating add of the offset into the translation column.
   always_comb begin
      logic signed [32:0] sum;
      htc_pkg::clip_type  clip;
      trans_sat = 1'b0;
      for (int j = 0; j < 3; j++) begin
         sum          = {t_ff[j][3][31], t_ff[j][3]} + {elem[j][31], elem[j]};
         clip         = htc_pkg::clip_word(htc_pkg::CLIP_IN_W'(sum));
         trans_val[j] = clip.value;
         trans_sat    = trans_sat | clip.sat;
      end
   end

   // ------------------------------------------------------- lane operands
   // Lane j forms column j of the left row times T. For an inverse row, lane 3
   // takes the negated column of the rotation against the translation instead.
   always_comb begin
      for (int j = 0; j < 4; j++) begin
         for (int k = 0; k < 4; k++) begin
            lane_a[j][k] = {elem[k][31], elem[k]};
            lane_b[j][k] = t_ff[k][j];
         end
      end
      if (op == htc_pkg::OP_INV_ROW) begin
         for (int k = 0; k < 3; k++) begin
            lane_a[3][k] = -{t_ff[k][row][31], t_ff[k][row]};
         end
         lane_a[3][3] = '0;
      end
   end

   for (genvar j = 0; j < htc_pkg::LANES; j++) begin : g_lane
      htc_lane #(
         .FRAC_BITS (FRAC_BITS)
      ) u_lane (
         .clock   (clock),
         .load    (accept),
         .a_in    (lane_a[j]),
         .b_in    (lane_b[j]),
         .sum_out (lane_sum[j]),
         .sat_out (lane_sat[j])
      );
   end

   // ------------------------------------------------------ product stage
   always_comb begin
      s1_in        = s1_ff;
      s1_pass_in   = s1_pass_ff;
      s1_sat_in    = s1_sat_ff;
      if (s1_fire) begin
         s1_in.valid = 1'b0;
      end
      if (accept) begin
         s1_in.valid  = 1'b1;
         s1_in.kind   = htc_pkg::RES_PASS;
         s1_in.row    = '0;
         s1_in.commit = 1'b0;
         s1_sat_in    = 1'b0;
         for (int j = 0; j < 4; j++) begin
            s1_pass_in[j] = '0;
         end
         unique case (op)
            htc_pkg::OP_MUL_ROW: begin
               s1_in.kind   = htc_pkg::RES_PRODUCT;
               s1_in.row    = row;
               s1_in.commit = (row == 2'd3);
            end
            htc_pkg::OP_TRANSLATE: begin
               for (int j = 0; j < 3; j++) begin
                  s1_pass_in[j] = trans_val[j];
               end
               s1_sat_in = trans_sat;
            end
            htc_pkg::OP_READ_ROW: begin
               s1_in.row  = row;
               s1_pass_in = t_ff[row];
            end
            htc_pkg::OP_INV_ROW: begin
               s1_in.row = row;
               if (row == 2'd3) begin
                  s1_pass_in = t_ff[3];
               end else begin
                  s1_in.kind = htc_pkg::RES_INVERSE;
                  for (int k = 0; k < 3; k++) begin
                     s1_pass_in[k] = t_ff[k][row];
                  end
               end
            end
            default: begin
               // identity and unused codes answer with an all-zero row 0
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff <= '0;
      end else begin
         s1_ff <= s1_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_pass_ff <= s1_pass_in;
      s1_sat_ff  <= s1_sat_in;
   end

   // ------------------------------------------------- transform update
   // Identity and translate write at acceptance; products write when they leave
   // the product stage. The ready rule keeps the two apart.
   always_comb begin
      t_in    = t_ff;
      pend_in = pend_ff;
      if (accept && (op == htc_pkg::OP_IDENTITY)) begin
         for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
               t_in[i][j] = (i == j) ? ONE_Q : '0;
            end
         end
      end else if (accept && (op == htc_pkg::OP_TRANSLATE)) begin
         for (int j = 0; j < 3; j++) begin
            t_in[j][3] = trans_val[j];
         end
      end
      if (s1_fire && (s1_ff.kind == htc_pkg::RES_PRODUCT)) begin
         if (s1_ff.commit) begin
            for (int i = 0; i < 3; i++) begin
               t_in[i] = pend_ff[i];
            end
            t_in[3] = lane_sum;
         end else begin
            pend_in[s1_ff.row] = lane_sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
               t_ff[i][j] <= (i == j) ? ONE_Q : '0;
            end
         end
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 4; j++) begin
               pend_ff[i][j] <= '0;
            end
         end
      end else begin
         t_ff    <= t_in;
         pend_ff <= pend_in;
      end
   end

   // ---------------------------------------------------------- merge stage
   htc_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .ctl        (s1_ff),
      .pass_val   (s1_pass_ff),
      .pass_sat   (s1_sat_ff),
      .lane_sum   (lane_sum),
      .lane_sat   (lane_sat),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .out_free   (out_free)
   );

`ifndef NO_ASSERTIONS
   a_no_accept_over_commit: assert property (@(posedge clock) disable iff (reset)
      (s1_ff.valid && s1_ff.commit) |-> !accept)
      else $error("word accepted while a commit was in the product stage");

   a_identity_loads: assert property (@(posedge clock) disable iff (reset)
      (accept && (op == htc_pkg::OP_IDENTITY)) |=>
         (t_ff[0][0] == ONE_Q) && (t_ff[3][3] == ONE_Q) && (t_ff[0][3] == '0))
      else $error("identity did not load");

   a_fire_reaches_output: assert property (@(posedge clock) disable iff (reset)
      s1_fire |=> rsp_tvalid)
      else $error("product stage word lost on the way to the output");

   a_commit_row3: assert property (@(posedge clock) disable iff (reset)
      commit_fire |=> (t_ff[3][0] == $past(lane_sum[0])) &&
                      (t_ff[3][3] == $past(lane_sum[3])))
      else $error("row 3 commit did not take the lane results");
`endif

endmodule
